// File: sv/mbss_pkg.sv
// Shared constants and types of the masked byte signature search.
`default_nettype none

package mbss_pkg;

   // Window depth in bytes and width of the byte counter.
   localparam int MAX_PATTERN = 16;
   localparam int OFFSET_BITS = 32;
   // Width of the reported match offset.
   localparam int MATCH_OFFSET_BITS = 32;
   // Width of the pattern length register.
   localparam int LEN_BITS = 5;
   // Configuration port widths.
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 64;
   localparam int CARE_BITS = 16;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_LOW  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_HIGH = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CARE_MASK    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_LEN  = 3'd3;

   // Byte window, newest byte at index 0.
   typedef logic [MAX_PATTERN-1:0][7:0] window_type;

   // Signature aligned to the window: entry i is compared with window byte i.
   typedef struct packed {
      logic [MAX_PATTERN-1:0][7:0] sig_bytes;
      logic [MAX_PATTERN-1:0]      care;
      logic [LEN_BITS-1:0]         length;
   } pattern_type;

endpackage

`default_nettype wire

// File: sv/masked_byte_signature_search.sv
// Masked byte signature search: top level with request and result stages.
//
// Requests carry one byte of a memory region, in address order, and a flag
// on the region's last byte. The block looks for a signature of up to 16
// bytes, any of which may be a wildcard, and on the last byte returns one
// result: whether the signature occurred and the offset of its first match
// (zero when not found). Non-last bytes return nothing.
// The signature, care mask and length are set through the csr_ write port,
// which takes a write on every cycle that csr_write_enable is high; write
// only while no request is in flight.
// A result is registered in the result stage when its last byte leaves the request stage.
// Throughput: one byte per cycle, set by the loop that shifts the window,
// compares it with the signature and updates the byte counter.
// A stalled result holds rsp_valid and its fields; bytes keep flowing while
// it waits, and only a further last byte waits for the result stage.
// Reset empties both stages, restores the register defaults (length one,
// no care bits, zero signature) and clears the region state. After each
// result the region state clears for the next region.
`default_nettype none

module masked_byte_signature_search (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [7:0]                          req_byte_value,
   input  wire logic                                req_last_byte,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_found,
   output logic [mbss_pkg::MATCH_OFFSET_BITS-1:0]   rsp_match_offset,
   input  wire logic                                csr_write_enable,
   input  wire logic [mbss_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [mbss_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   mbss_pkg::pattern_type pattern;
   mbss_pkg::window_type  window_ff, window_in;

   logic                               in_valid_ff, in_valid_in;
   logic [7:0]                         in_byte_ff;
   logic                               in_last_ff;
   logic                               advance;

   logic [mbss_pkg::OFFSET_BITS-1:0]   seen_ff, seen_in, seen_next;
   logic                               match_ff, match_in;
   logic [mbss_pkg::OFFSET_BITS-1:0]   first_ff, first_in;
   logic                               hit, hit_now;
   logic [mbss_pkg::OFFSET_BITS-1:0]   len_wide, offset_now;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_found_ff, rsp_found_in;
   logic [mbss_pkg::OFFSET_BITS-1:0]   rsp_offset_ff, rsp_offset_in;

   mbss_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .pattern          (pattern)
   );

   // The held request moves on unless it is a last byte and the result
   // stage is still full.
   assign advance   = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Request stage.
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_byte_value;
         in_last_ff <= req_last_byte;
      end
   end

   // Window after the held byte is shifted in, newest at index 0.
   assign window_in = {window_ff[mbss_pkg::MAX_PATTERN-2:0], in_byte_ff};

   mbss_matcher u_matcher (
      .window  (window_in),
      .pattern (pattern),
      .hit     (hit)
   );

   // Saturating byte count and the first match position.
   assign seen_next  = (&seen_ff) ? seen_ff : seen_ff + 1'b1;
   assign len_wide   = mbss_pkg::OFFSET_BITS'(pattern.length);
   assign hit_now    = !match_ff && hit && (seen_next >= len_wide);
   assign offset_now = seen_next - len_wide;

   always_comb begin
      seen_in  = seen_next;
      match_in = match_ff || hit_now;
      first_in = match_ff ? first_ff : (hit_now ? offset_now : first_ff);
      // The region state clears behind each last byte.
      if (in_last_ff) begin
         seen_in  = '0;
         match_in = 1'b0;
         first_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= '0;
         match_ff <= 1'b0;
         first_ff <= '0;
      end else if (advance) begin
         seen_ff  <= seen_in;
         match_ff <= match_in;
         first_ff <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         window_ff <= window_in;
      end
   end

   // Result stage, loaded on a last byte.
   assign rsp_found_in  = match_ff || hit_now;
   assign rsp_offset_in = match_ff ? first_ff : (hit_now ? offset_now : '0);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         rsp_found_ff  <= rsp_found_in;
         rsp_offset_ff <= rsp_offset_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_match_offset = rsp_offset_ff[mbss_pkg::MATCH_OFFSET_BITS-1:0];

   // A result without a match reports offset zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_offset_ff == '0)
      else $error("unmatched result with non-zero offset");

   // The region state is clear after a last byte.
   assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> seen_ff == '0 && !match_ff && first_ff == '0)
      else $error("region state not cleared after last byte");

   // A recorded match never starts beyond the bytes counted so far.
   assert property (@(posedge clock) disable iff (reset)
      match_ff |-> first_ff <= seen_ff)
      else $error("match offset beyond byte count");

   // A result appears only behind an advancing last byte.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && in_last_ff))
      else $error("result without a last byte");

endmodule

`default_nettype wire

// File: sv/mbss_csr.sv
// Configuration registers and alignment of the signature to the byte window.
`default_nettype none

module mbss_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_enable,
   input  wire logic [mbss_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [mbss_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   output mbss_pkg::pattern_type                   pattern
);

   logic [63:0]                     pat_low_ff, pat_low_in;
   logic [63:0]                     pat_high_ff, pat_high_in;
   logic [mbss_pkg::CARE_BITS-1:0]  care_ff, care_in;
   logic [mbss_pkg::LEN_BITS-1:0]   len_ff, len_in;
   logic [mbss_pkg::LEN_BITS-1:0]   eff_len;
   logic [127:0]                    sig_flat;

   // Register writes; an index beyond the list is ignored.
   always_comb begin
      pat_low_in  = pat_low_ff;
      pat_high_in = pat_high_ff;
      care_in     = care_ff;
      len_in      = len_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            mbss_pkg::REG_PATTERN_LOW:  pat_low_in  = csr_write_data[63:0];
            mbss_pkg::REG_PATTERN_HIGH: pat_high_in = csr_write_data[63:0];
            mbss_pkg::REG_CARE_MASK:    care_in     = csr_write_data[mbss_pkg::CARE_BITS-1:0];
            mbss_pkg::REG_PATTERN_LEN:  len_in      = csr_write_data[mbss_pkg::LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         care_ff     <= '0;
         len_ff      <= mbss_pkg::LEN_BITS'(1);
      end else begin
         pat_low_ff  <= pat_low_in;
         pat_high_ff <= pat_high_in;
         care_ff     <= care_in;
         len_ff      <= len_in;
      end
   end

   // Lengths above the window depth are clamped to it.
   assign eff_len = (len_ff > mbss_pkg::LEN_BITS'(mbss_pkg::MAX_PATTERN)) ?
                    mbss_pkg::LEN_BITS'(mbss_pkg::MAX_PATTERN) : len_ff;
   assign sig_flat = {pat_high_ff, pat_low_ff};

   // Signature byte j lands on window byte length-1-j; positions past the
   // length carry no care bit.
   always_comb begin
      logic [mbss_pkg::LEN_BITS-1:0] j;
      pattern.length = eff_len;
      for (int i = 0; i < mbss_pkg::MAX_PATTERN; i++) begin
         j = eff_len - mbss_pkg::LEN_BITS'(i) - mbss_pkg::LEN_BITS'(1);
         pattern.sig_bytes[i] = sig_flat[8*j[3:0] +: 8];
         pattern.care[i]      = (mbss_pkg::LEN_BITS'(i) < eff_len) && care_ff[j[3:0]];
      end
   end

endmodule

`default_nettype wire

// File: sv/mbss_matcher.sv
// Parallel masked comparison of the byte window with the aligned signature.
`default_nettype none

module mbss_matcher (
   input  wire mbss_pkg::window_type  window,
   input  wire mbss_pkg::pattern_type pattern,
   output logic                       hit
);

   logic [mbss_pkg::MAX_PATTERN-1:0] byte_ok;

   // Each window byte either is a wildcard or equals its signature byte.
   always_comb begin
      for (int i = 0; i < mbss_pkg::MAX_PATTERN; i++) begin
         byte_ok[i] = !pattern.care[i] || (window[i] == pattern.sig_bytes[i]);
      end
   end

   // A zero length never matches.
   assign hit = (&byte_ok) && (pattern.length != '0);

endmodule

`default_nettype wire
